FILE: src/assert_macros.svh
// Assertion macros for the checker in sfd_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted
`define SFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen on a clock edge outside reset
`define SFD_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: src/sfd_pkg.sv
`timescale 1ns / 1ps

package sfd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned MODE_W    = 2;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 1'd1;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RESET  = 8'h55;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RESET = 8'hAA;

    localparam logic [BYTE_W-1:0] MIN_LEN    = 8'd6;
    localparam logic [BYTE_W-1:0] MODE_MAX   = 8'd3;
    localparam logic [BYTE_W-1:0] RESULT_MAX = 8'd1;

    localparam logic [BYTE_W-1:0] IDX_FIRST  = 8'd1;
    localparam logic [BYTE_W-1:0] IDX_SECOND = 8'd2;
    localparam logic [BYTE_W-1:0] IDX_LEN    = 8'd3;
    localparam logic [BYTE_W-1:0] IDX_MODE   = 8'd3;
    localparam logic [BYTE_W-1:0] IDX_RESULT = 8'd4;

    localparam logic [STATUS_W-1:0] ST_GOOD    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SUM_ERR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNUSED  = 2'd3;

    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_LEN,
        PH_BODY
    } phase_t;

    typedef struct packed {
        logic [STATUS_W-1:0] frame_status;
        logic [MODE_W-1:0]   mode_code;
        logic                mode_valid;
        logic                result_flag;
        logic                result_valid;
    } result_t;

endpackage

FILE: src/sfd_parser.sv
`timescale 1ns / 1ps

module sfd_parser
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfd_pkg::BYTE_W-1:0]   cfg_data,
    input  logic                         step,
    input  logic [sfd_pkg::BYTE_W-1:0]   byte_in,
    output logic                         emit,
    output sfd_pkg::result_t             result
);

    logic [sfd_pkg::BYTE_W-1:0] header_first_reg;
    logic [sfd_pkg::BYTE_W-1:0] header_second_reg;

    sfd_pkg::phase_t            phase_reg;
    sfd_pkg::phase_t            phase_next;
    logic [sfd_pkg::BYTE_W-1:0] index_reg;
    logic [sfd_pkg::BYTE_W-1:0] index_next;
    logic [sfd_pkg::BYTE_W-1:0] length_reg;
    logic [sfd_pkg::BYTE_W-1:0] length_next;
    logic [sfd_pkg::BYTE_W-1:0] sum_reg;
    logic [sfd_pkg::BYTE_W-1:0] sum_next;
    logic [sfd_pkg::BYTE_W-1:0] mode_reg;
    logic [sfd_pkg::BYTE_W-1:0] mode_next;
    logic [sfd_pkg::BYTE_W-1:0] res_reg;
    logic [sfd_pkg::BYTE_W-1:0] res_next;

    logic                       last_byte;

    assign last_byte = ({1'b0, index_reg} + 9'd1) >= {1'b0, length_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg  <= sfd_pkg::HEADER_FIRST_RESET;
            header_second_reg <= sfd_pkg::HEADER_SECOND_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sfd_pkg::CFG_HEADER_FIRST:  header_first_reg  <= cfg_data;
                sfd_pkg::CFG_HEADER_SECOND: header_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= sfd_pkg::PH_HUNT1;
            index_reg  <= '0;
            length_reg <= '0;
            sum_reg    <= '0;
            mode_reg   <= '0;
            res_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            index_reg  <= index_next;
            length_reg <= length_next;
            sum_reg    <= sum_next;
            mode_reg   <= mode_next;
            res_reg    <= res_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        index_next  = index_reg;
        length_next = length_reg;
        sum_next    = sum_reg;
        mode_next   = mode_reg;
        res_next    = res_reg;
        emit        = 1'b0;
        result      = '0;

        case (phase_reg)
            sfd_pkg::PH_HUNT2:
            begin
                if (byte_in == header_second_reg)
                begin
                    sum_next   = sum_reg + byte_in;
                    index_next = sfd_pkg::IDX_SECOND;
                    phase_next = sfd_pkg::PH_LEN;
                end
                else if (byte_in == header_first_reg)
                begin
                    phase_next  = sfd_pkg::PH_HUNT2;
                    index_next  = sfd_pkg::IDX_FIRST;
                    length_next = '0;
                    sum_next    = byte_in;
                    mode_next   = '0;
                    res_next    = '0;
                end
                else
                begin
                    phase_next  = sfd_pkg::PH_HUNT1;
                    index_next  = '0;
                    length_next = '0;
                    sum_next    = '0;
                    mode_next   = '0;
                    res_next    = '0;
                end
            end
            sfd_pkg::PH_LEN:
            begin
                if (byte_in < sfd_pkg::MIN_LEN)
                begin
                    emit                = 1'b1;
                    result.frame_status = sfd_pkg::ST_BAD_LEN;
                    phase_next          = sfd_pkg::PH_HUNT1;
                    index_next          = '0;
                    length_next         = '0;
                    sum_next            = '0;
                    mode_next           = '0;
                    res_next            = '0;
                end
                else
                begin
                    length_next = byte_in;
                    sum_next    = sum_reg + byte_in;
                    index_next  = sfd_pkg::IDX_LEN;
                    phase_next  = sfd_pkg::PH_BODY;
                end
            end
            sfd_pkg::PH_BODY:
            begin
                if (last_byte)
                begin
                    emit = 1'b1;
                    if (byte_in == sum_reg)
                    begin
                        result.frame_status = sfd_pkg::ST_GOOD;
                        if (mode_reg <= sfd_pkg::MODE_MAX)
                        begin
                            result.mode_code  = mode_reg[sfd_pkg::MODE_W-1:0];
                            result.mode_valid = 1'b1;
                        end
                        if (res_reg <= sfd_pkg::RESULT_MAX)
                        begin
                            result.result_flag  = res_reg[0];
                            result.result_valid = 1'b1;
                        end
                    end
                    else
                    begin
                        result.frame_status = sfd_pkg::ST_SUM_ERR;
                    end
                    phase_next  = sfd_pkg::PH_HUNT1;
                    index_next  = '0;
                    length_next = '0;
                    sum_next    = '0;
                    mode_next   = '0;
                    res_next    = '0;
                end
                else
                begin
                    if (index_reg == sfd_pkg::IDX_MODE)
                    begin
                        mode_next = byte_in;
                    end
                    else if (index_reg == sfd_pkg::IDX_RESULT)
                    begin
                        res_next = byte_in;
                    end
                    sum_next   = sum_reg + byte_in;
                    index_next = index_reg + 8'd1;
                end
            end
            default:
            begin
                if (byte_in == header_first_reg)
                begin
                    phase_next  = sfd_pkg::PH_HUNT2;
                    index_next  = sfd_pkg::IDX_FIRST;
                    sum_next    = byte_in;
                end
                else
                begin
                    phase_next  = sfd_pkg::PH_HUNT1;
                    index_next  = '0;
                    sum_next    = '0;
                end
                length_next = '0;
                mode_next   = '0;
                res_next    = '0;
            end
        endcase
    end

endmodule

FILE: src/serial_frame_deframer_sum_check.sv
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// input     in_valid / in_ready       rx_byte
// output    out_valid / out_ready     frame_status, mode_code, mode_valid,
//                                     result_flag, result_valid
// config    cfg_write                 cfg_index, cfg_data
//
// One word per cycle unless a held result stalls a frame-ending word: a word is
// registered, parsed and, at frame end, its result registered.
// The frame state machine updates once per word; throughput is set by that loop.
// Reset (rst_n low, asynchronous) restores header bytes 0x55/0xAA and hunting.
// A held result stalls only a word that ends a frame; other words keep flowing.

module serial_frame_deframer_sum_check
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sfd_pkg::BYTE_W-1:0]    rx_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sfd_pkg::STATUS_W-1:0]  frame_status,
    output logic [sfd_pkg::MODE_W-1:0]    mode_code,
    output logic                          mode_valid,
    output logic                          result_flag,
    output logic                          result_valid,
    input  logic                          cfg_write,
    input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfd_pkg::BYTE_W-1:0]    cfg_data
);

    logic                       in_valid_reg;
    logic [sfd_pkg::BYTE_W-1:0] in_byte_reg;
    logic                       out_valid_reg;
    sfd_pkg::result_t           out_result_reg;

    logic                       step;
    logic                       emit;
    sfd_pkg::result_t           result;

    // hold a frame-ending word while the result register is still occupied
    assign step     = in_valid_reg && (!emit || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    sfd_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .byte_in   (in_byte_reg),
        .emit      (emit),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (step && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= rx_byte;
        end
        if (step && emit)
        begin
            out_result_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_status = out_result_reg.frame_status;
    assign mode_code    = out_result_reg.mode_code;
    assign mode_valid   = out_result_reg.mode_valid;
    assign result_flag  = out_result_reg.result_flag;
    assign result_valid = out_result_reg.result_valid;

endmodule

FILE: src/sfd_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfd_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [sfd_pkg::STATUS_W-1:0]  frame_status,
    input logic [sfd_pkg::MODE_W-1:0]    mode_code,
    input logic                          mode_valid,
    input logic                          result_flag,
    input logic                          result_valid
);

    logic       out_stall;
    logic       out_fail;
    logic [4:0] out_fields;
    logic [6:0] out_word;

    assign out_stall  = out_valid && !out_ready;
    assign out_fail   = out_valid && frame_status != sfd_pkg::ST_GOOD;
    assign out_fields = {mode_code, mode_valid, result_flag, result_valid};
    assign out_word   = {frame_status, out_fields};

    `SFD_ASSERT(a_out_hold, out_stall |=> out_valid, "result word dropped while stalled")
    `SFD_ASSERT(a_out_stable, out_stall |=> $stable(out_word), "stalled result word changed")
    `SFD_NEVER(a_status_code, out_valid && frame_status == sfd_pkg::ST_UNUSED, "unknown status")
    `SFD_ASSERT(a_bad_frame_clear, out_fail |-> out_fields == '0, "fields set on a failed frame")
    `SFD_ASSERT(a_invalid_zero, out_valid |-> (mode_valid || mode_code == '0), "mode without valid")

endmodule

bind serial_frame_deframer_sum_check sfd_checker u_sfd_checker (.*);

FILE: tb/sfd_frame_checker.sv
`timescale 1ns / 1ps

module sfd_frame_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [sfd_pkg::BYTE_W-1:0]    rx_byte,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [sfd_pkg::STATUS_W-1:0]  frame_status,
    input  logic [sfd_pkg::MODE_W-1:0]    mode_code,
    input  logic                          mode_valid,
    input  logic                          result_flag,
    input  logic                          result_valid,
    input  logic                          cfg_write,
    input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfd_pkg::BYTE_W-1:0]    cfg_data,
    output int                            mismatches,
    output int                            awaited,
    output int                            words_seen,
    output int                            frames_seen
);

    logic [sfd_pkg::BYTE_W-1:0] hdr_first;
    logic [sfd_pkg::BYTE_W-1:0] hdr_second;
    sfd_pkg::phase_t            ph;
    logic [sfd_pkg::BYTE_W-1:0] idx;
    logic [sfd_pkg::BYTE_W-1:0] flen;
    logic [sfd_pkg::BYTE_W-1:0] sum;
    logic [sfd_pkg::BYTE_W-1:0] mode_b;
    logic [sfd_pkg::BYTE_W-1:0] res_b;
    sfd_pkg::result_t           awaited_frames[$];
    int                         err_n;
    int                         word_n;
    int                         frame_n;

    task automatic restart_hunt();
        ph     = sfd_pkg::PH_HUNT1;
        idx    = '0;
        flen   = '0;
        sum    = '0;
        mode_b = '0;
        res_b  = '0;
    endtask

    task automatic open_frame(input logic [sfd_pkg::BYTE_W-1:0] b);
        restart_hunt();
        ph  = sfd_pkg::PH_HUNT2;
        sum = b;
        idx = sfd_pkg::IDX_FIRST;
    endtask

    task automatic parse_rx_byte(input logic [sfd_pkg::BYTE_W-1:0] b, output bit done,
                                 output sfd_pkg::result_t r);
        done = 1'b0;
        r    = '0;
        case (ph)
            sfd_pkg::PH_HUNT2:
            begin
                if (b == hdr_second)
                begin
                    sum = sum + b;
                    idx = sfd_pkg::IDX_SECOND;
                    ph  = sfd_pkg::PH_LEN;
                end
                else if (b == hdr_first)
                    open_frame(b);
                else
                    restart_hunt();
            end
            sfd_pkg::PH_LEN:
            begin
                if (b < sfd_pkg::MIN_LEN)
                begin
                    r.frame_status = sfd_pkg::ST_BAD_LEN;
                    done = 1'b1;
                    restart_hunt();
                end
                else
                begin
                    flen = b;
                    sum  = sum + b;
                    idx  = sfd_pkg::IDX_LEN;
                    ph   = sfd_pkg::PH_BODY;
                end
            end
            sfd_pkg::PH_BODY:
            begin
                if ({1'b0, idx} + 9'd1 >= {1'b0, flen})
                begin
                    if (b == sum)
                    begin
                        r.frame_status = sfd_pkg::ST_GOOD;
                        if (mode_b <= sfd_pkg::MODE_MAX)
                        begin
                            r.mode_code  = mode_b[sfd_pkg::MODE_W-1:0];
                            r.mode_valid = 1'b1;
                        end
                        if (res_b <= sfd_pkg::RESULT_MAX)
                        begin
                            r.result_flag  = res_b[0];
                            r.result_valid = 1'b1;
                        end
                    end
                    else
                        r.frame_status = sfd_pkg::ST_SUM_ERR;
                    done = 1'b1;
                    restart_hunt();
                end
                else
                begin
                    if (idx == sfd_pkg::IDX_MODE)
                        mode_b = b;
                    else if (idx == sfd_pkg::IDX_RESULT)
                        res_b = b;
                    sum = sum + b;
                    idx = idx + 8'd1;
                end
            end
            default:
            begin
                if (b == hdr_first)
                    open_frame(b);
                else
                    restart_hunt();
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        bit               done;
        sfd_pkg::result_t exp_r;
        sfd_pkg::result_t got_r;
        if (!rst_n)
        begin
            hdr_first  = sfd_pkg::HEADER_FIRST_RESET;
            hdr_second = sfd_pkg::HEADER_SECOND_RESET;
            restart_hunt();
            awaited_frames.delete();
            err_n   = 0;
            word_n  = 0;
            frame_n = 0;
            mismatches  <= 0;
            awaited     <= 0;
            words_seen  <= 0;
            frames_seen <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got_r.frame_status = frame_status;
                got_r.mode_code    = mode_code;
                got_r.mode_valid   = mode_valid;
                got_r.result_flag  = result_flag;
                got_r.result_valid = result_valid;
                frame_n++;
                if (awaited_frames.size() == 0)
                begin
                    if (err_n < 10)
                        $display("unexpected frame result %0d: status %0d mode %0d/%0d %s %0d/%0d",
                                 frame_n, got_r.frame_status, got_r.mode_code,
                                 got_r.mode_valid, "result", got_r.result_flag,
                                 got_r.result_valid);
                    err_n++;
                end
                else
                begin
                    exp_r = awaited_frames.pop_front();
                    if (got_r.frame_status !== exp_r.frame_status ||
                        got_r.mode_code    !== exp_r.mode_code    ||
                        got_r.mode_valid   !== exp_r.mode_valid   ||
                        got_r.result_flag  !== exp_r.result_flag  ||
                        got_r.result_valid !== exp_r.result_valid)
                    begin
                        if (err_n < 10)
                        begin
                            $display("frame %0d mismatch: expected status %0d mode %0d/%0d %s",
                                     frame_n, exp_r.frame_status, exp_r.mode_code,
                                     exp_r.mode_valid,
                                     $sformatf("result %0d/%0d", exp_r.result_flag,
                                               exp_r.result_valid));
                            $display("                    actual   status %0d mode %0d/%0d %s",
                                     got_r.frame_status, got_r.mode_code,
                                     got_r.mode_valid,
                                     $sformatf("result %0d/%0d", got_r.result_flag,
                                               got_r.result_valid));
                        end
                        err_n++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                parse_rx_byte(rx_byte, done, exp_r);
                if (done)
                    awaited_frames.push_back(exp_r);
                word_n++;
            end
            if (cfg_write)
            begin
                if (cfg_index == sfd_pkg::CFG_HEADER_FIRST)
                    hdr_first = cfg_data;
                else if (cfg_index == sfd_pkg::CFG_HEADER_SECOND)
                    hdr_second = cfg_data;
            end
            mismatches  <= err_n;
            awaited     <= awaited_frames.size();
            words_seen  <= word_n;
            frames_seen <= frame_n;
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int WORDS_PER_PHASE = 140;
    localparam int HOLD_CYCLES     = 300;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 8;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [sfd_pkg::BYTE_W-1:0]    rx_byte;
    logic                          out_valid;
    logic                          out_ready;
    logic [sfd_pkg::STATUS_W-1:0]  frame_status;
    logic [sfd_pkg::MODE_W-1:0]    mode_code;
    logic                          mode_valid;
    logic                          result_flag;
    logic                          result_valid;
    logic                          cfg_write;
    logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [sfd_pkg::BYTE_W-1:0]    cfg_data;

    int                            mismatches;
    int                            awaited;
    int                            words_seen;
    int                            frames_seen;

    bit                            calm = 1'b0;
    int                            holds_asked = 0;
    int                            holds_served = 0;
    int                            stall_cycles = 0;
    int                            words_sent = 0;
    logic [sfd_pkg::BYTE_W-1:0]    h1 = sfd_pkg::HEADER_FIRST_RESET;
    logic [sfd_pkg::BYTE_W-1:0]    h2 = sfd_pkg::HEADER_SECOND_RESET;

    serial_frame_deframer_sum_check i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frame_status (frame_status),
        .mode_code    (mode_code),
        .mode_valid   (mode_valid),
        .result_flag  (result_flag),
        .result_valid (result_valid),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    sfd_frame_checker i_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frame_status (frame_status),
        .mode_code    (mode_code),
        .mode_valid   (mode_valid),
        .result_flag  (result_flag),
        .result_valid (result_valid),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .awaited      (awaited),
        .words_seen   (words_seen),
        .frames_seen  (frames_seen)
    );

    always #4 clk = ~clk;

    function automatic bit idle_now();
        return !calm && ($urandom_range(0, 99) < 10);
    endfunction

    task automatic send_word(input logic [sfd_pkg::BYTE_W-1:0] b);
        while (idle_now())
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'($urandom);
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_frame(input int len, input logic [sfd_pkg::BYTE_W-1:0] mode_b,
                              input logic [sfd_pkg::BYTE_W-1:0] res_b,
                              input logic [sfd_pkg::BYTE_W-1:0] spoil);
        logic [sfd_pkg::BYTE_W-1:0] sum;
        logic [sfd_pkg::BYTE_W-1:0] b;
        sum = h1 + h2 + len[7:0] + mode_b + res_b;
        send_word(h1);
        send_word(h2);
        send_word(len[7:0]);
        send_word(mode_b);
        send_word(res_b);
        for (int i = 5; i < len - 1; i++)
        begin
            b   = 8'($urandom);
            sum = sum + b;
            send_word(b);
        end
        send_word(sum ^ spoil);
    endtask

    task automatic random_words(input int count);
        int                         start;
        int                         pick;
        int                         len;
        logic [sfd_pkg::BYTE_W-1:0] mode_b;
        logic [sfd_pkg::BYTE_W-1:0] res_b;
        logic [sfd_pkg::BYTE_W-1:0] spoil;
        start = words_sent;
        while (words_sent - start < count)
        begin
            pick   = $urandom_range(0, 99);
            mode_b = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
            res_b  = $urandom_range(0, 1) ? 8'($urandom_range(0, 1)) : 8'($urandom);
            spoil  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
            len    = ($urandom_range(0, 99) < 3) ? $urandom_range(13, 255)
                                                 : $urandom_range(6, 12);
            if (pick < 62)
                send_frame(len, mode_b, res_b, spoil);
            else if (pick < 72)
            begin
                send_word(h1);
                send_word(h2);
                send_word(8'($urandom_range(0, sfd_pkg::MIN_LEN - 1)));
            end
            else if (pick < 80)
            begin
                send_word(h1);
                send_word(8'($urandom));
            end
            else if (pick < 86)
            begin
                send_word(h1);
                send_frame(len, mode_b, res_b, 8'h00);
            end
            else
                repeat ($urandom_range(1, 4))
                    send_word(8'($urandom));
        end
    endtask

    // drop valid and drain every outstanding frame result
    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic set_headers(input logic [sfd_pkg::BYTE_W-1:0] first,
                               input logic [sfd_pkg::BYTE_W-1:0] second);
        cfg_write <= 1'b1;
        cfg_index <= sfd_pkg::CFG_HEADER_FIRST;
        cfg_data  <= first;
        @(posedge clk);
        cfg_index <= sfd_pkg::CFG_HEADER_SECOND;
        cfg_data  <= second;
        @(posedge clk);
        cfg_write <= 1'b0;
        h1 = first;
        h2 = second;
    endtask

    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (holds_asked > holds_served)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                holds_served++;
            end
            else
                out_ready <= !idle_now();
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[serial_frame_deframer_sum_check] ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [sfd_pkg::BYTE_W-1:0] first_tbl [5];
        logic [sfd_pkg::BYTE_W-1:0] second_tbl [5];
        first_tbl  = '{8'h00, 8'hFF, 8'h7E, 8'h00, sfd_pkg::HEADER_FIRST_RESET};
        second_tbl = '{8'hFF, 8'h00, 8'h7E, 8'h00, sfd_pkg::HEADER_SECOND_RESET};
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        cfg_write = 1'b0;
        cfg_index = sfd_pkg::CFG_HEADER_FIRST;
        cfg_data  = '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(h1);
        send_frame(6, 8'h03, 8'h01, 8'h00);
        send_word(h1);
        send_word(h2);
        send_word(8'h05);
        send_frame(6, 8'hFF, 8'h02, 8'h00);
        send_frame(6, 8'h01, 8'h00, 8'h01);
        send_word(h1);
        send_word(8'h12);

        for (int k = 0; k < 5; k++)
        begin
            quiesce();
            if (k == 3)
            begin
                first_tbl[k]  = 8'($urandom);
                second_tbl[k] = 8'($urandom);
            end
            set_headers(first_tbl[k], second_tbl[k]);
            calm = (k == 2);
            if (k == 1)
            begin
                // hold the output side off while frames keep arriving
                holds_asked++;
                repeat (5)
                    send_frame(6, 8'($urandom_range(0, 3)), 8'($urandom_range(0, 1)), 8'h00);
            end
            random_words(WORDS_PER_PHASE);
            if (k == 4)
                send_frame(255, 8'h02, 8'h01, 8'h00);
        end
        quiesce();

        $display("covered %0d words and %0d frame results across six header settings,",
                 words_seen, frames_seen);
        $display("with bad lengths, checksum errors, resyncs and an output hold-off");
        if (mismatches == 0 && awaited == 0)
            $display("[serial_frame_deframer_sum_check] OK");
        else
            $display("[serial_frame_deframer_sum_check] ERROR");
        $finish;
    end

endmodule
